// ===== src/lcw_pkg.sv =====
// lcw_pkg: shared constants, register indexes and flag structs for the
// lidar curvature window block. no dependencies.
`timescale 1ns / 1ps

package lcw_pkg;

    // default geometry of the window and the coordinate word
    localparam int HALF_WINDOW_DEF = 5;
    localparam int COORD_BITS_DEF  = 18;

    // curvature word, fixed by the result format
    localparam int                CURV_W   = 45;
    localparam logic [CURV_W-1:0] CURV_MAX = '1;

    // configuration port
    localparam int                CFG_DATA_W    = 64;
    localparam int                CFG_ADDR_W    = 4;
    localparam int                CFG_IDX_LSB   = 3;
    localparam logic [0:0]        REG_CURV_THRESHOLD = 1'b0;
    localparam logic [CURV_W-1:0] THRESHOLD_RESET    = 45'd5242880;

    // flags that travel with a point from the window into the curvature pipe
    typedef struct packed {
        logic has_curv;
        logic last;
    } pt_flags_t;

    // flags that leave with a result
    typedef struct packed {
        logic has_curv;
        logic masked;
        logic last;
    } res_flags_t;

endpackage

// ===== src/lcw_cell.sv =====
// lcw_cell: one stage of the point window, holds a point and its tags and
// hands them on to the next cell on every shift. depends on lcw_pkg.
`timescale 1ns / 1ps

module lcw_cell
    import lcw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic signed [COORD_BITS-1:0] d_x,
    input  logic signed [COORD_BITS-1:0] d_y,
    input  logic signed [COORD_BITS-1:0] d_z,
    input  logic                         d_present,
    input  logic                         d_id,
    input  logic                         d_last,
    output logic signed [COORD_BITS-1:0] q_x,
    output logic signed [COORD_BITS-1:0] q_y,
    output logic signed [COORD_BITS-1:0] q_z,
    output logic                         q_present,
    output logic                         q_id,
    output logic                         q_last
);

    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] z_reg;
    logic                         present_reg;
    logic                         id_reg;
    logic                         last_reg;

    // data is cleared too: the window sums track the cell contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            present_reg <= 1'b0;
            id_reg      <= 1'b0;
            last_reg    <= 1'b0;
        end
        else if (shift)
        begin
            x_reg       <= d_x;
            y_reg       <= d_y;
            z_reg       <= d_z;
            present_reg <= d_present;
            id_reg      <= d_id;
            last_reg    <= d_last;
        end
    end

    assign q_x       = x_reg;
    assign q_y       = y_reg;
    assign q_z       = z_reg;
    assign q_present = present_reg;
    assign q_id      = id_reg;
    assign q_last    = last_reg;

endmodule

// ===== src/lcw_curv.sv =====
// lcw_curv: pipelined curvature of the centre point (difference, square,
// sum of axes, saturate and threshold) with the output register. depends on lcw_pkg.
`timescale 1ns / 1ps

module lcw_curv
    import lcw_pkg::*;
#(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int WIN_LEN    = 2 * HALF_WINDOW + 1,
    localparam int S_W        = COORD_BITS + $clog2(WIN_LEN)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CURV_W-1:0]            threshold,
    // centre point and window sums
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    input  logic signed [S_W-1:0]        sum_x,
    input  logic signed [S_W-1:0]        sum_y,
    input  logic signed [S_W-1:0]        sum_z,
    input  pt_flags_t                    in_flags,
    // result
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic [CURV_W-1:0]            out_curv,
    output res_flags_t                   out_flags
);

    localparam int MAG_W = COORD_BITS + $clog2(2 * HALF_WINDOW) + 1;
    localparam int D_W   = MAG_W + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int TOT_W = SQ_W + 2;
    localparam int CMP_W = (TOT_W > CURV_W) ? TOT_W : CURV_W;
    localparam logic signed [D_W-1:0] WIN_MUL = D_W'(WIN_LEN);

    // stage valids
    logic va_reg, vb_reg, vc_reg, vo_reg;
    logic en_a, en_b, en_c, en_o;

    // stage a: absolute differences
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [MAG_W-1:0] mag_x_next, mag_y_next, mag_z_next;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, az_reg;
    pt_flags_t fa_reg;

    // stage b: squares
    logic [SQ_W-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [COORD_BITS-1:0] bx_reg, by_reg, bz_reg;
    pt_flags_t fb_reg;

    // stage c: sum over axes
    logic [TOT_W-1:0] tot_reg;
    logic [TOT_W-1:0] tot_next;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    pt_flags_t fc_reg;

    // output stage
    logic [CMP_W-1:0]  tot_ext;
    logic [CURV_W-1:0] curv_next;
    logic [CURV_W-1:0] curv_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg, oz_reg;
    res_flags_t fo_reg;
    res_flags_t fo_next;

    assign en_o     = !vo_reg || out_ready;
    assign en_c     = !vc_reg || en_o;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // neighbour sum minus ten times centre = window sum minus eleven times centre
    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [S_W-1:0]        s,
        input logic signed [COORD_BITS-1:0] c,
        input logic                         en
    );
        logic signed [D_W-1:0] d;
        logic signed [D_W-1:0] a;
        d = D_W'(s) - D_W'(c) * WIN_MUL;
        a = (d < 0) ? -d : d;
        return en ? a[MAG_W-1:0] : '0;
    endfunction

    always_comb
    begin
        mag_x_next = abs_diff(sum_x, in_x, in_flags.has_curv);
        mag_y_next = abs_diff(sum_y, in_y, in_flags.has_curv);
        mag_z_next = abs_diff(sum_z, in_z, in_flags.has_curv);
    end

    assign tot_next = TOT_W'(sq_x_reg) + TOT_W'(sq_y_reg) + TOT_W'(sq_z_reg);
    assign tot_ext  = CMP_W'(tot_reg);

    always_comb
    begin
        if (tot_ext > CMP_W'(CURV_MAX))
        begin
            curv_next = CURV_MAX;
        end
        else
        begin
            curv_next = tot_ext[CURV_W-1:0];
        end
        fo_next.has_curv = fc_reg.has_curv;
        fo_next.masked   = fc_reg.has_curv && (curv_next > threshold);
        fo_next.last     = fc_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= in_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
            if (en_c)
            begin
                vc_reg <= vb_reg;
            end
            if (en_o)
            begin
                vo_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            mag_z_reg <= mag_z_next;
            ax_reg    <= in_x;
            ay_reg    <= in_y;
            az_reg    <= in_z;
            fa_reg    <= in_flags;
        end
        if (en_b)
        begin
            sq_x_reg <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
            sq_y_reg <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
            sq_z_reg <= SQ_W'(mag_z_reg) * SQ_W'(mag_z_reg);
            bx_reg   <= ax_reg;
            by_reg   <= ay_reg;
            bz_reg   <= az_reg;
            fb_reg   <= fa_reg;
        end
        if (en_c)
        begin
            tot_reg <= tot_next;
            cx_reg  <= bx_reg;
            cy_reg  <= by_reg;
            cz_reg  <= bz_reg;
            fc_reg  <= fb_reg;
        end
        if (en_o)
        begin
            curv_reg <= curv_next;
            ox_reg   <= cx_reg;
            oy_reg   <= cy_reg;
            oz_reg   <= cz_reg;
            fo_reg   <= fo_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign out_curv  = curv_reg;
    assign out_flags = fo_reg;

endmodule

// ===== src/lidar_curvature_window.sv =====
// lidar_curvature_window: top level, a chain of point cells with running
// window sums, sweep flush control and the threshold register.
// depends on lcw_pkg, lcw_cell and lcw_curv.
//
//  channel  | direction | transaction
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | one lidar point, tlast marks the end of a sweep
//  m_*      | out       | one delayed point with curvature and flags
//  apb      | in/out    | curvature threshold register at byte address 0
//
// one point per clock while s_tready is high; a result leaves the output register after
// its point reaches the centre cell (HALF_WINDOW points after it entered) and passes
// the curv stages a, b and c. after a sweep end the chain shifts HALF_WINDOW more
// times with empty cells to flush the sweep; s_tready stays low until they are done.
// reset empties the window and the pipe and loads the default threshold.
// a stalled output fills the four pipe stages before s_tready drops.
`timescale 1ns / 1ps

module lidar_curvature_window
    import lcw_pkg::*;
#(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int IN_W       = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((3 * COORD_BITS + CURV_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // points in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // coord_x, coord_y, coord_z
    input  logic                  s_tlast,   // sweep_end
    // results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // pt_x, pt_y, pt_z, curvature
    output logic [1:0]            m_tuser,   // has_curvature, masked
    output logic                  m_tlast,   // sweep_last
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int S_W     = COORD_BITS + $clog2(WIN_LEN);
    localparam int FL_W    = $clog2(HALF_WINDOW + 1);

    // chain
    logic signed [COORD_BITS-1:0] x_d [WIN_LEN];
    logic signed [COORD_BITS-1:0] y_d [WIN_LEN];
    logic signed [COORD_BITS-1:0] z_d [WIN_LEN];
    logic                         pres_d [WIN_LEN];
    logic                         id_d [WIN_LEN];
    logic                         last_d [WIN_LEN];
    logic signed [COORD_BITS-1:0] x_q [WIN_LEN];
    logic signed [COORD_BITS-1:0] y_q [WIN_LEN];
    logic signed [COORD_BITS-1:0] z_q [WIN_LEN];
    logic                         pres_q [WIN_LEN];
    logic                         id_q [WIN_LEN];
    logic                         last_q [WIN_LEN];

    logic signed [COORD_BITS-1:0] new_x, new_y, new_z;

    // control
    logic            chain_en;
    logic            in_acc;
    logic            shift;
    logic            flushing;
    logic [FL_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic            id_reg, id_next;
    logic            fresh_reg, fresh_next;
    logic            full_run;
    logic            curv_ready;
    pt_flags_t       centre_flags;

    // running window sums
    logic signed [S_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [S_W-1:0] sum_x_next, sum_y_next, sum_z_next;

    // configuration
    logic              cfg_wr;
    logic [CURV_W-1:0] threshold_reg;

    // results
    logic                         res_valid;
    logic signed [COORD_BITS-1:0] res_x, res_y, res_z;
    logic [CURV_W-1:0]            res_curv;
    res_flags_t                   res_flags;

    assign flushing = (flush_cnt_reg != '0);
    assign chain_en = !fresh_reg || curv_ready;
    assign s_tready = chain_en && !flushing;
    assign in_acc   = s_tvalid && s_tready;
    assign shift    = in_acc || (flushing && chain_en);

    // empty cells are shifted in while flushing
    assign new_x = in_acc ? $signed(s_tdata[COORD_BITS-1:0]) : '0;
    assign new_y = in_acc ? $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]) : '0;
    assign new_z = in_acc ? $signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]) : '0;

    genvar k;
    generate
        for (k = 0; k < WIN_LEN; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign x_d[k]    = new_x;
                assign y_d[k]    = new_y;
                assign z_d[k]    = new_z;
                assign pres_d[k] = in_acc;
                assign id_d[k]   = id_reg;
                assign last_d[k] = in_acc && s_tlast;
            end
            else
            begin : g_link
                assign x_d[k]    = x_q[k-1];
                assign y_d[k]    = y_q[k-1];
                assign z_d[k]    = z_q[k-1];
                assign pres_d[k] = pres_q[k-1];
                assign id_d[k]   = id_q[k-1];
                assign last_d[k] = last_q[k-1];
            end

            lcw_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .d_x       (x_d[k]),
                .d_y       (y_d[k]),
                .d_z       (z_d[k]),
                .d_present (pres_d[k]),
                .d_id      (id_d[k]),
                .d_last    (last_d[k]),
                .q_x       (x_q[k]),
                .q_y       (y_q[k]),
                .q_z       (z_q[k]),
                .q_present (pres_q[k]),
                .q_id      (id_q[k]),
                .q_last    (last_q[k])
            );
        end
    endgenerate

    // centre point has full neighbourhoods when every cell holds a point of its sweep
    always_comb
    begin
        full_run = 1'b1;
        for (int i = 0; i < WIN_LEN; i++)
        begin
            full_run = full_run && pres_q[i] && (id_q[i] == id_q[HALF_WINDOW]);
        end
        centre_flags.has_curv = full_run;
        centre_flags.last     = last_q[HALF_WINDOW];
    end

    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        if (shift)
        begin
            sum_x_next = sum_x_reg + S_W'(new_x) - S_W'(x_q[WIN_LEN-1]);
            sum_y_next = sum_y_reg + S_W'(new_y) - S_W'(y_q[WIN_LEN-1]);
            sum_z_next = sum_z_reg + S_W'(new_z) - S_W'(z_q[WIN_LEN-1]);
        end
    end

    always_comb
    begin
        flush_cnt_next = flush_cnt_reg;
        id_next        = id_reg;
        fresh_next     = fresh_reg;
        if (in_acc && s_tlast)
        begin
            flush_cnt_next = FL_W'(HALF_WINDOW);
            id_next        = !id_reg;
        end
        else if (shift && flushing)
        begin
            flush_cnt_next = flush_cnt_reg - FL_W'(1);
        end
        if (chain_en)
        begin
            fresh_next = shift && pres_q[HALF_WINDOW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_cnt_reg <= '0;
            id_reg        <= 1'b0;
            fresh_reg     <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
        end
        else
        begin
            flush_cnt_reg <= flush_cnt_next;
            id_reg        <= id_next;
            fresh_reg     <= fresh_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_z_reg     <= sum_z_next;
        end
    end

    lcw_curv #(
        .HALF_WINDOW (HALF_WINDOW),
        .COORD_BITS  (COORD_BITS)
    ) u_curv (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .in_valid  (fresh_reg),
        .in_ready  (curv_ready),
        .in_x      (x_q[HALF_WINDOW]),
        .in_y      (y_q[HALF_WINDOW]),
        .in_z      (z_q[HALF_WINDOW]),
        .sum_x     (sum_x_reg),
        .sum_y     (sum_y_reg),
        .sum_z     (sum_z_reg),
        .in_flags  (centre_flags),
        .out_valid (res_valid),
        .out_ready (m_tready),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_z     (res_z),
        .out_curv  (res_curv),
        .out_flags (res_flags)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = OUT_W'({res_curv, res_z, res_y, res_x});
    assign m_tuser  = {res_flags.masked, res_flags.has_curv};
    assign m_tlast  = res_flags.last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr && (paddr[CFG_IDX_LSB] == REG_CURV_THRESHOLD))
        begin
            threshold_reg <= pwdata[CURV_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_IDX_LSB] == REG_CURV_THRESHOLD) ?
                    CFG_DATA_W'(threshold_reg) : '0;

endmodule

// ===== tb/sv/tb_lidar_curvature_window.sv =====
`timescale 1ns / 1ps
// tb_lidar_curvature_window: self-checking bench for the lidar curvature window.
// sends point sweeps on the stream port, sets the threshold over apb and checks
// each result against a window model kept here. needs lcw_pkg and the rtl.

module tb_lidar_curvature_window;
    import lcw_pkg::*;

    localparam int HW          = HALF_WINDOW_DEF;
    localparam int CB          = COORD_BITS_DEF;
    localparam int WIN_LEN     = 2 * HW + 1;
    localparam int IN_W        = ((3 * CB + 7) / 8) * 8;
    localparam int OUT_W       = ((3 * CB + CURV_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS = 10;
    localparam int COORD_HI    = 2 ** (CB - 1) - 1;
    localparam int COORD_LO    = -(2 ** (CB - 1));

    localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR =
        CFG_ADDR_W'(REG_CURV_THRESHOLD) << CFG_IDX_LSB;

    typedef logic signed [CB-1:0] coord_t;

    localparam coord_t COORD_MIN = {1'b1, {(CB - 1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(CB - 1){1'b1}}};

    typedef struct packed {
        logic [CB-1:0]     x;
        logic [CB-1:0]     y;
        logic [CB-1:0]     z;
        logic [CURV_W-1:0] curv;
        logic              has_curv;
        logic              masked;
        logic              last;
    } point_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;   // coord_x, coord_y, coord_z
    logic                  s_tlast  = 1'b0; // sweep_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;         // pt_x, pt_y, pt_z, curvature
    logic [1:0]            m_tuser;         // has_curvature, masked
    logic                  m_tlast;         // sweep_last
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // window model
    coord_t            win_x [WIN_LEN];
    coord_t            win_y [WIN_LEN];
    coord_t            win_z [WIN_LEN];
    int                fill_count;
    logic [CURV_W-1:0] threshold;
    point_result_t     expected_points [$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int points_sent = 0;
    int sweeps_sent = 0;
    int results_checked = 0;
    int curved_seen = 0;
    int masked_seen = 0;
    int threshold_writes = 0;

    point_result_t seen_result;
    point_result_t due_result;

    lidar_curvature_window dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic string describe(input point_result_t r);
        return $sformatf("x=%0d y=%0d z=%0d curv=%0d has=%b masked=%b last=%b",
                         $signed(r.x), $signed(r.y), $signed(r.z), r.curv,
                         r.has_curv, r.masked, r.last);
    endfunction

    // squared norm of neighbour sum minus ten times the centre, per axis
    function automatic logic [CURV_W-1:0] window_curvature();
        longint          sx;
        longint          sy;
        longint          sz;
        longint unsigned total;
        sx = 0;
        sy = 0;
        sz = 0;
        for (int k = 0; k < WIN_LEN; k++)
        begin
            if (k != HW)
            begin
                sx += win_x[k];
                sy += win_y[k];
                sz += win_z[k];
            end
        end
        sx -= 2 * HW * win_x[HW];
        sy -= 2 * HW * win_y[HW];
        sz -= 2 * HW * win_z[HW];
        if (sx < 0) sx = -sx;
        if (sy < 0) sy = -sy;
        if (sz < 0) sz = -sz;
        total = sx * sx + sy * sy + sz * sz;
        // saturation only bites with wider coordinates
        if (total > CURV_MAX)
            total = CURV_MAX;
        return total[CURV_W-1:0];
    endfunction

    function automatic void queue_point(input int k, input logic curv, input logic last_one);
        point_result_t r;
        r.x        = win_x[k];
        r.y        = win_y[k];
        r.z        = win_z[k];
        r.curv     = curv ? window_curvature() : '0;
        r.has_curv = curv;
        r.masked   = curv && (r.curv > threshold);
        r.last     = last_one;
        expected_points.insert(expected_points.size(), r);
    endfunction

    function automatic void advance_window(input coord_t x, input coord_t y, input coord_t z,
                                           input logic sweep_end);
        int top;
        for (int k = WIN_LEN - 1; k > 0; k--)
        begin
            win_x[k] = win_x[k - 1];
            win_y[k] = win_y[k - 1];
            win_z[k] = win_z[k - 1];
        end
        win_x[0] = x;
        win_y[0] = y;
        win_z[0] = z;
        if (fill_count < WIN_LEN)
            fill_count++;
        if (!sweep_end)
        begin
            if (fill_count > HW)
                queue_point(HW, fill_count == WIN_LEN, 1'b0);
        end
        else
        begin
            // flush: remaining newer points go out oldest first
            top = (fill_count - 1 < HW) ? fill_count - 1 : HW;
            for (int k = top; k >= 0; k--)
                queue_point(k, (k == HW) && (fill_count == WIN_LEN), k == 0);
            fill_count = 0;
        end
    endfunction

    function automatic coord_t random_coord(input int mode, input coord_t base, input int span);
        int v;
        case (mode)
            0: return coord_t'($urandom);
            1:
            begin
                v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
                if (v > COORD_HI) v = COORD_HI;
                if (v < COORD_LO) v = COORD_LO;
                return coord_t'(v);
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return coord_t'($urandom);
                endcase
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic sweep_end);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 3 * CB){1'b0}}, z, y, x};
        s_tlast  <= sweep_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_window(x, y, z, sweep_end);
        points_sent++;
        if (sweep_end)
            sweeps_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (write)
        begin
            threshold = value[CURV_W-1:0];
            threshold_writes++;
        end
        else if (prdata !== CFG_DATA_W'(threshold))
            note_mismatch($sformatf("threshold read: expected %0d, got %0d",
                                    threshold, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(input logic [CURV_W-1:0] value);
        wait_drained();
        apb_access(1'b1, CFG_DATA_W'(value));
        apb_access(1'b0, '0);
    endtask

    task automatic send_random_sweep(input bit allow_idle);
        int     len;
        int     mode;
        int     span;
        coord_t bx;
        coord_t by;
        coord_t bz;
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * HW)
                                           : $urandom_range(WIN_LEN, 20);
        mode = $urandom_range(0, 2);
        span = 1 << $urandom_range(0, 12);
        bx   = coord_t'($urandom);
        by   = coord_t'($urandom);
        bz   = coord_t'($urandom);
        tx_idle = allow_idle && ($urandom_range(0, 3) != 0);
        rx_idle = allow_idle && ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++)
            send_point(random_coord(mode, bx, span), random_coord(mode, by, span),
                       random_coord(mode, bz, span), k == len - 1);
    endtask

    task automatic test_register_reset();
        apb_access(1'b0, '0);
    endtask

    // sweeps too short to give any point curvature
    task automatic test_short_sweeps();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_point(COORD_MIN, COORD_MAX, '0, 1'b1);
        for (int k = 0; k < HW; k++)
            send_point(k[0] ? COORD_MAX : COORD_MIN, coord_t'(-k), coord_t'(k * 1000),
                       k == HW - 1);
    endtask

    // centre against opposite extremes: largest curvature, masked at reset threshold
    task automatic test_extreme_curvature();
        for (int k = 0; k < WIN_LEN; k++)
        begin
            if (k == HW)
                send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
            else
                send_point(COORD_MIN, COORD_MAX, COORD_MIN, k == WIN_LEN - 1);
        end
    endtask

    // lone unit spike gives curvatures 100 and 1; threshold 1 masks only the first
    task automatic test_threshold_boundary();
        set_threshold(CURV_W'(1));
        for (int k = 0; k <= WIN_LEN; k++)
            send_point(k == HW ? coord_t'(1) : coord_t'(0), '0, '0, k == WIN_LEN);
    endtask

    task automatic test_random_sweeps();
        logic [CURV_W-1:0] settings [4];
        int                start;
        settings[0] = '0;
        settings[1] = CURV_MAX;
        settings[2] = CURV_W'($urandom_range(0, 1 << 24));
        settings[3] = CURV_W'({$urandom, $urandom});
        for (int p = 0; p < 4; p++)
        begin
            set_threshold(settings[p]);
            start = points_sent;
            while (points_sent - start < 10)
                send_random_sweep(1'b1);
        end
    endtask

    // last part: no gaps on either side
    task automatic test_back_to_back();
        int start;
        set_threshold(THRESHOLD_RESET);
        start = points_sent;
        while (points_sent - start < 12)
            send_random_sweep(1'b0);
    endtask

    always @(negedge clk)
    begin
        if (!rx_idle)
            m_tready <= 1'b1;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            rx_stall_left = $urandom_range(0, 17);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.x        = m_tdata[0 +: CB];
            seen_result.y        = m_tdata[CB +: CB];
            seen_result.z        = m_tdata[2 * CB +: CB];
            seen_result.curv     = m_tdata[3 * CB +: CURV_W];
            seen_result.has_curv = m_tuser[0];
            seen_result.masked   = m_tuser[1];
            seen_result.last     = m_tlast;
            results_checked++;
            if (seen_result.has_curv)
                curved_seen++;
            if (seen_result.masked)
                masked_seen++;
            if (expected_points.size() == 0)
                note_mismatch({"result with nothing expected: ", describe(seen_result)});
            else
            begin
                due_result = expected_points.pop_front();
                if (due_result !== seen_result)
                    note_mismatch({"expected ", describe(due_result),
                                   ", got ", describe(seen_result)});
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no transaction for %0d cycles, giving up", STALL_LIMIT);
        $display("lidar_curvature_window: mismatch");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < WIN_LEN; k++)
        begin
            win_x[k] = '0;
            win_y[k] = '0;
            win_z[k] = '0;
        end
        fill_count = 0;
        threshold  = THRESHOLD_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_reset();
        test_short_sweeps();
        test_extreme_curvature();
        test_threshold_boundary();
        test_random_sweeps();
        test_back_to_back();
        wait_drained();

        $display("sent %0d points in %0d sweeps over %0d threshold writes, %0d results checked",
                 points_sent, sweeps_sent, threshold_writes, results_checked);
        $display("%0d results carried curvature, %0d of those masked, %0d mismatches",
                 curved_seen, masked_seen, mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("lidar_curvature_window: match");
        else
            $display("lidar_curvature_window: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lcw_pkg.sv
src/lcw_cell.sv
src/lcw_curv.sv
src/lidar_curvature_window.sv
tb/sv/tb_lidar_curvature_window.sv
